// ===== rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths and constants for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

  // Fixed point format of every field
  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;

  // Square root: radicand bits and root bits, one root bit per stage
  localparam int RAD_W       = 2 * (FRAC_BITS + 1);
  localparam int ROOT_W      = RAD_W / 2;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_STAGES = ROOT_W;

  // Antisymmetric differences and the divider; a difference of two full
  // range inputs, one of them negated, can reach +65536
  localparam int DIFF_W     = IN_W + 2;
  localparam int DVD_W      = DIFF_W + FRAC_BITS;
  localparam int DVS_W      = ROOT_W + 2;
  localparam int DIV_STAGES = DVD_W;

  // Output widths and saturation limit
  localparam int QW_W  = 15;
  localparam int Q_W   = 16;
  localparam int Q_MAX = 32767;

endpackage

`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Rotation matrix (three frame vectors) to quaternion, Q2.14, fully pipelined.
// ----------------------------------------------------------------------------
// Pipeline: 1 front stage, 15 square root stages, 32 divider stages and
//   1 output register, from input transfer to result valid.
// Throughput: one frame per cycle; the whole pipeline advances together and
//   holds while a finished result waits on out_ready.
// Reset: rst clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_quaternion_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [15:0]       approach_x,
  input  wire logic signed [15:0]       approach_y,
  input  wire logic signed [15:0]       approach_z,
  input  wire logic signed [15:0]       binormal_x,
  input  wire logic signed [15:0]       binormal_y,
  input  wire logic signed [15:0]       binormal_z,
  input  wire logic signed [15:0]       hand_axis_x,
  input  wire logic signed [15:0]       hand_axis_y,
  input  wire logic signed [15:0]       hand_axis_z,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic             [14:0]       quat_w,
  output logic signed      [15:0]       quat_x,
  output logic signed      [15:0]       quat_y,
  output logic signed      [15:0]       quat_z,
  output logic                          degenerate
);

  localparam int SN = rmq_pkg::SQRT_STAGES;
  localparam int DN = rmq_pkg::DIV_STAGES;
  localparam int F  = rmq_pkg::FRAC_BITS;
  localparam int SW = 19;

  typedef logic signed [rmq_pkg::DIFF_W-1:0] diff_t;
  typedef logic        [rmq_pkg::ROOT_W-1:0] root_t;

  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t dz;
  } diff3_t;

  typedef struct packed {
    root_t w;
    logic  deg;
    logic  nx;
    logic  ny;
    logic  nz;
    root_t rx;
    root_t ry;
    root_t rz;
  } side_t;

  logic en;

  // advance the whole pipeline unless a result is stuck at the output
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- front stage: radicands and differences ----------------
  logic signed [SW-1:0]        s_sum, d11, d22, d33;
  logic [rmq_pkg::RAD_W-1:0]   rad_w_n, rad_x_n, rad_y_n, rad_z_n;
  diff3_t                      diff_n;

  function automatic logic [rmq_pkg::RAD_W-1:0] clamp_rad(
    input logic signed [SW-1:0] v,
    input int                   sh
  );
    logic [rmq_pkg::RAD_W-1:0] u;
    u = v[SW-1] ? '0 : rmq_pkg::RAD_W'(v[SW-2:0]);
    return u << sh;
  endfunction

  always_comb begin
    s_sum = SW'(1 << F) + SW'(approach_x) + SW'(binormal_y) - SW'(hand_axis_z);
    d11   = SW'(1 << F) + SW'(approach_x);
    d22   = SW'(1 << F) + SW'(binormal_y);
    d33   = SW'(1 << F) - SW'(hand_axis_z);
    rad_w_n = clamp_rad(s_sum, F - 2);
    rad_x_n = clamp_rad(d11, F - 1);
    rad_y_n = clamp_rad(d22, F - 1);
    rad_z_n = clamp_rad(d33, F - 1);
    diff_n.dx = -rmq_pkg::DIFF_W'(hand_axis_y) - rmq_pkg::DIFF_W'(binormal_z);
    diff_n.dy =  rmq_pkg::DIFF_W'(approach_z)  + rmq_pkg::DIFF_W'(hand_axis_x);
    diff_n.dz =  rmq_pkg::DIFF_W'(binormal_x)  - rmq_pkg::DIFF_W'(approach_y);
  end

  logic                      fr_valid;
  logic [rmq_pkg::RAD_W-1:0] rad_w, rad_x, rad_y, rad_z;
  diff3_t                    fr_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (en) begin
      fr_valid <= in_valid;
    end
    if (en) begin
      rad_w   <= rad_w_n;
      rad_x   <= rad_x_n;
      rad_y   <= rad_y_n;
      rad_z   <= rad_z_n;
      fr_diff <= diff_n;
    end
  end

  // ---------------- square roots ----------------
  root_t root_w, root_x, root_y, root_z;

  rmq_isqrt u_sqrt_w (.clk(clk), .en(en), .rad(rad_w), .root(root_w));
  rmq_isqrt u_sqrt_x (.clk(clk), .en(en), .rad(rad_x), .root(root_x));
  rmq_isqrt u_sqrt_y (.clk(clk), .en(en), .rad(rad_y), .root(root_y));
  rmq_isqrt u_sqrt_z (.clk(clk), .en(en), .rad(rad_z), .root(root_z));

  // carry valid and differences alongside the root stages
  logic   sq_valid [SN];
  diff3_t sq_diff  [SN];

  always_ff @(posedge clk) begin
    for (int k = 0; k < SN; k++) begin
      if (rst) begin
        sq_valid[k] <= 1'b0;
      end else if (en) begin
        sq_valid[k] <= (k == 0) ? fr_valid : sq_valid[(k == 0) ? 0 : k-1];
      end
      if (en) begin
        sq_diff[k] <= (k == 0) ? fr_diff : sq_diff[(k == 0) ? 0 : k-1];
      end
    end
  end

  // ---------------- divider operands ----------------
  diff3_t                    dq;
  logic [rmq_pkg::DVS_W-1:0] divisor;
  logic [rmq_pkg::DVD_W-1:0] dvd_x, dvd_y, dvd_z;
  side_t                     side_n;

  function automatic logic [rmq_pkg::DVD_W-1:0] mag_shift(input diff_t d);
    logic [rmq_pkg::DIFF_W-1:0] m;
    m = d[rmq_pkg::DIFF_W-1] ? rmq_pkg::DIFF_W'(-d) : rmq_pkg::DIFF_W'(d);
    return {m, F'(0)};
  endfunction

  always_comb begin
    dq      = sq_diff[SN-1];
    divisor = {root_w, 2'b00};
    dvd_x   = mag_shift(dq.dx);
    dvd_y   = mag_shift(dq.dy);
    dvd_z   = mag_shift(dq.dz);
    side_n.w   = root_w;
    side_n.deg = (root_w == '0);
    side_n.nx  = dq.dx[rmq_pkg::DIFF_W-1];
    side_n.ny  = dq.dy[rmq_pkg::DIFF_W-1];
    side_n.nz  = dq.dz[rmq_pkg::DIFF_W-1];
    side_n.rx  = root_x;
    side_n.ry  = root_y;
    side_n.rz  = root_z;
  end

  logic [rmq_pkg::DVD_W-1:0] quo_x, quo_y, quo_z;

  rmq_div u_div_x (.clk(clk), .en(en), .dividend(dvd_x), .divisor(divisor), .quotient(quo_x));
  rmq_div u_div_y (.clk(clk), .en(en), .dividend(dvd_y), .divisor(divisor), .quotient(quo_y));
  rmq_div u_div_z (.clk(clk), .en(en), .dividend(dvd_z), .divisor(divisor), .quotient(quo_z));

  // carry valid and sideband alongside the divider stages
  logic  dv_valid [DN];
  side_t dv_side  [DN];

  always_ff @(posedge clk) begin
    for (int k = 0; k < DN; k++) begin
      if (rst) begin
        dv_valid[k] <= 1'b0;
      end else if (en) begin
        dv_valid[k] <= (k == 0) ? sq_valid[SN-1] : dv_valid[(k == 0) ? 0 : k-1];
      end
      if (en) begin
        dv_side[k] <= (k == 0) ? side_n : dv_side[(k == 0) ? 0 : k-1];
      end
    end
  end

  // ---------------- output: saturate, sign, select branch ----------------
  side_t sd;

  function automatic logic [rmq_pkg::Q_W-1:0] sat_signed(
    input logic [rmq_pkg::DVD_W-1:0] q,
    input logic                      neg
  );
    logic [rmq_pkg::Q_W-1:0] m;
    m = (q > rmq_pkg::DVD_W'(rmq_pkg::Q_MAX)) ? rmq_pkg::Q_W'(rmq_pkg::Q_MAX)
                                              : rmq_pkg::Q_W'(q);
    return neg ? rmq_pkg::Q_W'(-m) : m;
  endfunction

  function automatic logic [rmq_pkg::Q_W-1:0] sat_root(input root_t r);
    return (rmq_pkg::Q_W'(r) > rmq_pkg::Q_W'(rmq_pkg::Q_MAX))
           ? rmq_pkg::Q_W'(rmq_pkg::Q_MAX) : rmq_pkg::Q_W'(r);
  endfunction

  assign sd = dv_side[DN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid[DN-1];
    end
    if (en) begin
      quat_w     <= rmq_pkg::QW_W'(sd.w);
      degenerate <= sd.deg;
      quat_x     <= sd.deg ? sat_root(sd.rx) : sat_signed(quo_x, sd.nx);
      quat_y     <= sd.deg ? sat_root(sd.ry) : sat_signed(quo_y, sd.ny);
      quat_z     <= sd.deg ? sat_root(sd.rz) : sat_signed(quo_z, sd.nz);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rmq_isqrt.sv =====
// ----------------------------------------------------------------------------
// rmq_isqrt
// Pipelined integer square root, floor result, one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmq_isqrt (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [rmq_pkg::RAD_W-1:0]     rad,
  output logic      [rmq_pkg::ROOT_W-1:0]    root
);

  localparam int N = rmq_pkg::SQRT_STAGES;

  logic [rmq_pkg::REM_W-1:0]  rem_q  [N];
  logic [rmq_pkg::ROOT_W-1:0] root_q [N];
  logic [rmq_pkg::RAD_W-1:0]  rad_q  [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_stage
      logic [rmq_pkg::REM_W-1:0]  rem_in;
      logic [rmq_pkg::ROOT_W-1:0] root_in;
      logic [rmq_pkg::RAD_W-1:0]  rad_in;
      logic [rmq_pkg::REM_W+1:0]  rem_sh;
      logic [rmq_pkg::REM_W+1:0]  trial;
      logic                       ge;

      // take the previous stage, or the fresh radicand at the head
      if (i == 0) begin : g_head
        assign rem_in  = '0;
        assign root_in = '0;
        assign rad_in  = rad;
      end else begin : g_body
        assign rem_in  = rem_q[i-1];
        assign root_in = root_q[i-1];
        assign rad_in  = rad_q[i-1];
      end

      // bring down two radicand bits and try the next root bit
      always_comb begin
        rem_sh = {rem_in, rad_in[rmq_pkg::RAD_W-1 -: 2]};
        trial  = {(rmq_pkg::REM_W)'(root_in), 2'b01};
        ge     = (rem_sh >= trial);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i]  <= ge ? rmq_pkg::REM_W'(rem_sh - trial)
                          : rmq_pkg::REM_W'(rem_sh);
          root_q[i] <= {root_in[rmq_pkg::ROOT_W-2:0], ge};
          rad_q[i]  <= rad_in << 2;
        end
      end
    end
  endgenerate

  assign root = root_q[N-1];

endmodule

`default_nettype wire

// ===== rtl/rmq_div.sv =====
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmq_div (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [rmq_pkg::DVD_W-1:0]    dividend,
  input  wire logic [rmq_pkg::DVS_W-1:0]    divisor,
  output logic      [rmq_pkg::DVD_W-1:0]    quotient
);

  localparam int N = rmq_pkg::DIV_STAGES;

  logic [rmq_pkg::DVS_W-1:0] rem_q [N];
  logic [rmq_pkg::DVD_W-1:0] dvd_q [N];
  logic [rmq_pkg::DVS_W-1:0] dvs_q [N];
  logic [rmq_pkg::DVD_W-1:0] quo_q [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_stage
      logic [rmq_pkg::DVS_W-1:0] rem_in;
      logic [rmq_pkg::DVD_W-1:0] dvd_in;
      logic [rmq_pkg::DVS_W-1:0] dvs_in;
      logic [rmq_pkg::DVD_W-1:0] quo_in;
      logic [rmq_pkg::DVS_W:0]   rem_sh;
      logic                      ge;

      // take the previous stage, or the fresh operands at the head
      if (i == 0) begin : g_head
        assign rem_in = '0;
        assign dvd_in = dividend;
        assign dvs_in = divisor;
        assign quo_in = '0;
      end else begin : g_body
        assign rem_in = rem_q[i-1];
        assign dvd_in = dvd_q[i-1];
        assign dvs_in = dvs_q[i-1];
        assign quo_in = quo_q[i-1];
      end

      // shift in one dividend bit and subtract where it fits
      always_comb begin
        rem_sh = {rem_in, dvd_in[rmq_pkg::DVD_W-1]};
        ge     = (rem_sh >= {1'b0, dvs_in});
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= ge ? rmq_pkg::DVS_W'(rem_sh - {1'b0, dvs_in})
                         : rmq_pkg::DVS_W'(rem_sh);
          dvd_q[i] <= dvd_in << 1;
          dvs_q[i] <= dvs_in;
          quo_q[i] <= {quo_in[rmq_pkg::DVD_W-2:0], ge};
        end
      end
    end
  endgenerate

  assign quotient = quo_q[N-1];

endmodule

`default_nettype wire
